FILE: sv/imu_burst_frame_orient_scale_defines.svh
// Assertion macros for the IMU burst frame block.
// Both sample on clk and use rst_n, which must exist where they are used.
`ifndef IMU_BURST_FRAME_ORIENT_SCALE_DEFINES_SVH
`define IMU_BURST_FRAME_ORIENT_SCALE_DEFINES_SVH

// same-cycle implication, masked while in reset
`define IBFOS_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ibfos check failed");

// next-cycle implication, masked while in reset
`define IBFOS_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ibfos check failed");

`endif

FILE: sv/ibfos_pkg.sv
package ibfos_pkg;

  localparam int FRAME_BYTES = 13;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int STORE_DEPTH = FRAME_BYTES - 2;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  localparam int RAW_W  = 16;
  localparam int MULT_W = 14;
  localparam int X_W    = 29;
  localparam int RCP_W  = 30;
  localparam int Q_W    = 23;
  localparam int OUT_W  = 24;

  // accel: round(v*981*2^k/400) = floor((n+200)/400)
  // gyro : round(v*640*2^k/41)  = floor((n+20)/41)
  localparam logic [MULT_W-1:0] ACC_MUL  = MULT_W'(981);
  localparam logic [MULT_W-1:0] GYR_MUL  = MULT_W'(640);
  localparam logic [X_W-1:0]    ACC_BIAS = X_W'(200);
  localparam logic [X_W-1:0]    GYR_BIAS = X_W'(20);
  // exact reciprocals m = ceil(2^S/d); (m*d - 2^S) * 2^X_W < 2^S keeps
  // (x*m) >> S equal to floor(x/d) for every x below 2^X_W
  localparam logic [RCP_W-1:0]  ACC_RECIP = RCP_W'(343597384);
  localparam int                ACC_SHIFT = 37;
  localparam logic [RCP_W-1:0]  GYR_RECIP = RCP_W'(838042400);
  localparam int                GYR_SHIFT = 35;
  localparam logic [2:0]        GYR_SEL_MAX = 3'd4;

  typedef enum logic [1:0] {
    CFG_MOUNT       = 2'd0,
    CFG_ACCEL_RANGE = 2'd1,
    CFG_GYRO_RANGE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MNT_TOP_0   = 3'd0,
    MNT_TOP_90  = 3'd1,
    MNT_TOP_180 = 3'd2,
    MNT_TOP_270 = 3'd3,
    MNT_BOT_0   = 3'd4,
    MNT_BOT_90  = 3'd5,
    MNT_BOT_180 = 3'd6,
    MNT_BOT_270 = 3'd7
  } mount_t;

  typedef enum logic {
    SNS_ACCEL = 1'b0,
    SNS_GYRO  = 1'b1
  } sense_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] gx;
    logic signed [RAW_W-1:0] gy;
    logic signed [RAW_W-1:0] gz;
    logic signed [RAW_W-1:0] ax;
    logic signed [RAW_W-1:0] ay;
    logic signed [RAW_W-1:0] az;
  } frame_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctl_t;

endpackage

FILE: sv/ibfos_frame.sv
module ibfos_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic                  burst_start,
  output logic                  done,
  output ibfos_pkg::frame_t     frame_r
);

  logic [ibfos_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                  bytes_r [ibfos_pkg::STORE_DEPTH];
  logic                        wr_en;
  logic [ibfos_pkg::IDX_W-1:0] wr_idx;

  assign wr_idx = ibfos_pkg::IDX_W'(pos_r - ibfos_pkg::POS_W'(1));

  always_comb begin
    pos_nxt = pos_r;
    wr_en   = 1'b0;
    done    = 1'b0;
    if (accept) begin
      if (burst_start) begin
        pos_nxt = ibfos_pkg::POS_W'(1);
      end else if (pos_r == '0 ||
                   pos_r >= ibfos_pkg::POS_W'(ibfos_pkg::FRAME_BYTES)) begin
        pos_nxt = '0;
      end else if (pos_r < ibfos_pkg::POS_W'(ibfos_pkg::FRAME_BYTES - 1)) begin
        wr_en   = 1'b1;
        pos_nxt = pos_r + ibfos_pkg::POS_W'(1);
      end else begin
        done    = 1'b1;
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_r[wr_idx] <= rx_byte;
    end
  end

  // last byte goes straight into accel Z high
  always_ff @(posedge clk) begin
    if (done) begin
      frame_r.gx <= {bytes_r[1], bytes_r[0]};
      frame_r.gy <= {bytes_r[3], bytes_r[2]};
      frame_r.gz <= {bytes_r[5], bytes_r[4]};
      frame_r.ax <= {bytes_r[7], bytes_r[6]};
      frame_r.ay <= {bytes_r[9], bytes_r[8]};
      frame_r.az <= {rx_byte, bytes_r[10]};
    end
  end

endmodule

FILE: sv/ibfos_remap.sv
module ibfos_remap (
  input  ibfos_pkg::mount_t                    orient,
  input  logic signed [ibfos_pkg::RAW_W-1:0]   x,
  input  logic signed [ibfos_pkg::RAW_W-1:0]   y,
  input  logic signed [ibfos_pkg::RAW_W-1:0]   z,
  output logic [2:0][ibfos_pkg::RAW_W-1:0]     mag,
  output logic [2:0]                           neg
);

  // sign/magnitude of each axis; |-32768| = 0x8000 fits unsigned
  logic [ibfos_pkg::RAW_W-1:0] mx, my, mz;
  logic                        sx, sy, sz;

  assign sx = x[ibfos_pkg::RAW_W-1];
  assign sy = y[ibfos_pkg::RAW_W-1];
  assign sz = z[ibfos_pkg::RAW_W-1];
  assign mx = sx ? -x : x;
  assign my = sy ? -y : y;
  assign mz = sz ? -z : z;

  always_comb begin
    mag = {mz, my, mx};
    neg = {sz, sy, sx};
    case (orient)
      ibfos_pkg::MNT_TOP_0: begin
        mag = {mz, my, mx};  neg = {~sz, ~sy, sx};
      end
      ibfos_pkg::MNT_TOP_90: begin
        mag = {mz, mx, my};  neg = {~sz, sx, sy};
      end
      ibfos_pkg::MNT_TOP_180: begin
        mag = {mz, my, mx};  neg = {~sz, sy, ~sx};
      end
      ibfos_pkg::MNT_TOP_270: begin
        mag = {mz, mx, my};  neg = {~sz, ~sx, ~sy};
      end
      ibfos_pkg::MNT_BOT_0: begin
        mag = {mz, my, mx};  neg = {sz, sy, sx};
      end
      ibfos_pkg::MNT_BOT_90: begin
        mag = {mz, mx, my};  neg = {sz, sx, ~sy};
      end
      ibfos_pkg::MNT_BOT_180: begin
        mag = {mz, my, mx};  neg = {sz, ~sy, ~sx};
      end
      ibfos_pkg::MNT_BOT_270: begin
        mag = {mz, mx, my};  neg = {sz, ~sx, sy};
      end
      default: begin
        mag = {mz, my, mx};  neg = {sz, sy, sx};
      end
    endcase
  end

endmodule

FILE: sv/ibfos_scale.sv
module ibfos_scale (
  input  logic                                 clk,
  input  ibfos_pkg::pipe_ctl_t                 ctl,
  input  ibfos_pkg::sense_t                    kind,
  input  logic [ibfos_pkg::MULT_W-1:0]         mult,
  input  logic [ibfos_pkg::RAW_W-1:0]          mag,
  input  logic                                 neg,
  output logic signed [ibfos_pkg::OUT_W-1:0]   res_r
);

  localparam int P1_W = ibfos_pkg::RAW_W + ibfos_pkg::MULT_W;
  localparam int P2_W = ibfos_pkg::X_W + ibfos_pkg::RCP_W;

  logic [P1_W-1:0]             prod1;
  logic [ibfos_pkg::X_W-1:0]   bias;
  logic [ibfos_pkg::X_W-1:0]   x_nxt, x_r;
  logic                        neg_r;
  logic [ibfos_pkg::RCP_W-1:0] recip;
  logic [P2_W-1:0]             prod2;
  logic [ibfos_pkg::Q_W-1:0]   q;
  logic [ibfos_pkg::OUT_W-1:0] res_nxt;

  // stage 1: magnitude times range multiplier plus rounding bias
  assign prod1 = P1_W'(mag) * P1_W'(mult);
  assign x_nxt = ibfos_pkg::X_W'(prod1) + bias;

  always_comb begin
    case (kind)
      ibfos_pkg::SNS_ACCEL: begin
        bias  = ibfos_pkg::ACC_BIAS;
        recip = ibfos_pkg::ACC_RECIP;
      end
      ibfos_pkg::SNS_GYRO: begin
        bias  = ibfos_pkg::GYR_BIAS;
        recip = ibfos_pkg::GYR_RECIP;
      end
      default: begin
        bias  = ibfos_pkg::ACC_BIAS;
        recip = ibfos_pkg::ACC_RECIP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      x_r   <= x_nxt;
      neg_r <= neg;
    end
  end

  // stage 2: exact constant divide by reciprocal multiply
  assign prod2 = P2_W'(x_r) * P2_W'(recip);

  always_comb begin
    case (kind)
      ibfos_pkg::SNS_ACCEL: q = ibfos_pkg::Q_W'(prod2 >> ibfos_pkg::ACC_SHIFT);
      ibfos_pkg::SNS_GYRO:  q = ibfos_pkg::Q_W'(prod2 >> ibfos_pkg::GYR_SHIFT);
      default:              q = ibfos_pkg::Q_W'(prod2 >> ibfos_pkg::ACC_SHIFT);
    endcase
  end

  assign res_nxt = neg_r ? -{1'b0, q} : {1'b0, q};

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: sv/imu_burst_frame_orient_scale.sv
// IMU burst frame decoder: takes the 13 bytes of one SPI burst read, one byte per item
// (dummy byte flagged by in_tuser, then gyro XYZ and accel XYZ, little-endian s16), and
// on the last byte emits one item of six remapped, range-scaled values in Q.12 (accel
// m/s^2, gyro deg/s, round to nearest, ties away from zero). A byte is taken every cycle
// while in_tready is high. Frame register, lane stage and output register form a
// three-deep pipeline with per-stage ready; the lanes do range multiply, then exact
// reciprocal multiply for /400 or /41. Bytes keep flowing while a result waits until all
// are full. The user must make config changes only when idle; the block never checks it.
module imu_burst_frame_orient_scale (
  input  logic          clk,
  input  logic          rst_n,
  // input channel
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,    // [7:0] rx_byte
  input  logic          in_tuser,    // [0] burst_start
  // result channel
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [143:0]  out_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
                                     // (24 bits each, lowest first)
  // configuration
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [2:0]    cfg_wdata
);

  ibfos_pkg::mount_t             mount_r;
  logic [1:0]                    accel_range_r;
  logic [2:0]                    gyro_range_r;
  logic [2:0]                    gsel;
  logic [ibfos_pkg::MULT_W-1:0]  acc_mult, gyr_mult;

  logic                          in_acc, done;
  ibfos_pkg::frame_t             frame_r;
  logic                          s0_vld_r, s0_vld_nxt;
  logic                          s1_vld_r, s1_vld_nxt;
  logic                          s2_vld_r, s2_vld_nxt;
  logic                          s0_rdy, s1_rdy, s2_rdy;
  ibfos_pkg::pipe_ctl_t          ctl;

  logic [2:0][ibfos_pkg::RAW_W-1:0] acc_mag, gyr_mag;
  logic [2:0]                       acc_neg, gyr_neg;
  logic signed [ibfos_pkg::OUT_W-1:0] acc_res [3];
  logic signed [ibfos_pkg::OUT_W-1:0] gyr_res [3];

  // config registers; writes to the unused index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_r       <= ibfos_pkg::MNT_BOT_0;
      accel_range_r <= 2'd2;
      gyro_range_r  <= 3'd4;
    end else if (cfg_we) begin
      case (ibfos_pkg::cfg_idx_t'(cfg_index))
        ibfos_pkg::CFG_MOUNT:       mount_r       <= ibfos_pkg::mount_t'(cfg_wdata);
        ibfos_pkg::CFG_ACCEL_RANGE: accel_range_r <= cfg_wdata[1:0];
        ibfos_pkg::CFG_GYRO_RANGE:  gyro_range_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // gyro select codes above 2000 dps clamp to 2000 dps
  assign gsel     = (gyro_range_r > ibfos_pkg::GYR_SEL_MAX) ? ibfos_pkg::GYR_SEL_MAX
                                                            : gyro_range_r;
  assign acc_mult = ibfos_pkg::ACC_MUL << accel_range_r;
  assign gyr_mult = ibfos_pkg::GYR_MUL << gsel;

  // pipeline handshake: each stage takes when empty or draining
  assign s2_rdy    = !s2_vld_r || out_tready;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign s0_rdy    = !s0_vld_r || s1_rdy;
  assign in_tready = s0_rdy;
  assign in_acc    = in_tvalid && in_tready;

  assign ctl.s1_load = s0_vld_r && s1_rdy;
  assign ctl.s2_load = s1_vld_r && s2_rdy;

  always_comb begin
    s0_vld_nxt = s0_vld_r;
    s1_vld_nxt = s1_vld_r;
    s2_vld_nxt = s2_vld_r;
    if (ctl.s1_load) s0_vld_nxt = 1'b0;
    if (done)        s0_vld_nxt = 1'b1;
    if (ctl.s2_load) s1_vld_nxt = 1'b1;
    else if (s1_rdy) s1_vld_nxt = ctl.s1_load;
    if (ctl.s1_load) s1_vld_nxt = 1'b1;
    else if (ctl.s2_load) s1_vld_nxt = 1'b0;
    if (ctl.s2_load) s2_vld_nxt = 1'b1;
    else if (out_tready) s2_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= s0_vld_nxt;
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  ibfos_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .rx_byte     (in_tdata),
    .burst_start (in_tuser),
    .done        (done),
    .frame_r     (frame_r)
  );

  ibfos_remap u_remap_acc (
    .orient (mount_r),
    .x      (frame_r.ax),
    .y      (frame_r.ay),
    .z      (frame_r.az),
    .mag    (acc_mag),
    .neg    (acc_neg)
  );

  ibfos_remap u_remap_gyr (
    .orient (mount_r),
    .x      (frame_r.gx),
    .y      (frame_r.gy),
    .z      (frame_r.gz),
    .mag    (gyr_mag),
    .neg    (gyr_neg)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ibfos_scale u_acc (
      .clk   (clk),
      .ctl   (ctl),
      .kind  (ibfos_pkg::SNS_ACCEL),
      .mult  (acc_mult),
      .mag   (acc_mag[i]),
      .neg   (acc_neg[i]),
      .res_r (acc_res[i])
    );
    ibfos_scale u_gyr (
      .clk   (clk),
      .ctl   (ctl),
      .kind  (ibfos_pkg::SNS_GYRO),
      .mult  (gyr_mult),
      .mag   (gyr_mag[i]),
      .neg   (gyr_neg[i]),
      .res_r (gyr_res[i])
    );
  end

  assign out_tvalid = s2_vld_r;
  assign out_tdata  = {gyr_res[2], gyr_res[1], gyr_res[0],
                       acc_res[2], acc_res[1], acc_res[0]};

endmodule

FILE: sv/ibfos_checker.sv
`include "imu_burst_frame_orient_scale_defines.svh"

module ibfos_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tready,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [143:0]  out_tdata
);

  // stalled result holds
  `IBFOS_CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // empty output register means the pipe can always take a byte
  `IBFOS_CHK_NOW(a_in_free, !out_tvalid, in_tready)
  // no stale result right out of reset
  `IBFOS_CHK_NOW(a_rst_clear, $rose(rst_n), !out_tvalid)

endmodule

bind imu_burst_frame_orient_scale ibfos_checker u_chk (.*);
